// ===== rtl/int_to_decimal_ascii_core_defines.svh =====
// Assertion macros used by int_to_decimal_ascii_core.
`ifndef INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every edge once reset is released.
`define I2D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define I2D_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define I2D_ASSERT(lbl, prop, msg)
`define I2D_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/i2d_pkg.sv =====
`default_nettype none
package i2d_pkg;

	localparam int unsigned ValueWidth     = 32;
	localparam int unsigned NumDigits      = 10;
	localparam int unsigned DigitWidth     = 4;
	localparam int unsigned BcdWidth       = NumDigits * DigitWidth;
	localparam int unsigned CharWidth      = 8;
	localparam int unsigned DigitCntWidth  = $clog2(NumDigits + 1);
	localparam int unsigned StepCntWidth   = $clog2(ValueWidth);

	localparam logic [CharWidth-1:0] CharMinus = 8'd45;
	localparam logic [CharWidth-1:0] CharZero  = 8'd48;

	typedef logic [ValueWidth-1:0] mag_t;
	typedef logic [BcdWidth-1:0]   bcd_t;

	// start toward the converter, done back from it
	typedef struct packed {
		logic start;
		mag_t mag;
	} cvt_req_t;

	typedef struct packed {
		logic done;
		bcd_t bcd;
	} cvt_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/i2d_if.sv =====
`default_nettype none
interface i2d_num_if;
	logic                                valid;
	logic                                ready;
	logic signed [i2d_pkg::ValueWidth-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface i2d_text_if;
	logic                             valid;
	logic                             ready;
	logic [i2d_pkg::CharWidth-1:0]    text_char;
	logic                             last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink   (input valid, input text_char, input last_char, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2d_dabble.sv =====
`default_nettype none
// Bit-serial binary to BCD (shift and add-3), one input bit per cycle.
module i2d_dabble (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire i2d_pkg::cvt_req_t req,
	output i2d_pkg::cvt_rsp_t      rsp
);

	logic [i2d_pkg::ValueWidth-1:0]   bin_q;
	logic [i2d_pkg::BcdWidth-1:0]     bcd_q;
	logic [i2d_pkg::BcdWidth-1:0]     adj;
	logic [i2d_pkg::StepCntWidth-1:0] step_q;
	logic                             busy_q;
	logic                             done_q;

	// each digit that is 5 or more gets +3 before the shift
	always_comb begin
		for (int i = 0; i < int'(i2d_pkg::NumDigits); i++) begin
			if (bcd_q[i*i2d_pkg::DigitWidth +: i2d_pkg::DigitWidth] >= 4'd5) begin
				adj[i*i2d_pkg::DigitWidth +: i2d_pkg::DigitWidth] =
					bcd_q[i*i2d_pkg::DigitWidth +: i2d_pkg::DigitWidth] + 4'd3;
			end else begin
				adj[i*i2d_pkg::DigitWidth +: i2d_pkg::DigitWidth] =
					bcd_q[i*i2d_pkg::DigitWidth +: i2d_pkg::DigitWidth];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == i2d_pkg::StepCntWidth'(i2d_pkg::ValueWidth - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			bin_q <= req.mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[i2d_pkg::BcdWidth-2:0], bin_q[i2d_pkg::ValueWidth-1]};
			bin_q <= {bin_q[i2d_pkg::ValueWidth-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.bcd  = bcd_q;

endmodule
`default_nettype wire

// ===== rtl/int_to_decimal_ascii_core.sv =====
// The first character follows the value after the bit-serial conversion, then the ST_SKIP
// state drops each leading zero digit, up to 9.
// One item at a time: a new value is taken only once the last character of the previous one
// is loaded into the output register; the bit-serial BCD converter sets the bulk of the time.
// Characters leave at one per cycle while the sink keeps ready high.
// Reset (arst_n low, asynchronous) returns to idle and drops the output valid.
`default_nettype none
`include "int_to_decimal_ascii_core_defines.svh"
module int_to_decimal_ascii_core (
	input  wire               clk,
	input  wire               arst_n,
	i2d_num_if.sink           num,
	i2d_text_if.source        text
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	state_t                               state_q;
	logic                                 neg_q;
	logic [i2d_pkg::BcdWidth-1:0]         dig_q;
	logic [i2d_pkg::DigitCntWidth-1:0]    left_q;
	logic                                 text_valid_q;
	logic [i2d_pkg::CharWidth-1:0]        text_char_q;
	logic                                 last_q;

	i2d_pkg::cvt_req_t                    cvt_req;
	i2d_pkg::cvt_rsp_t                    cvt_rsp;
	logic                                 accept;
	logic                                 slot_free;
	logic                                 text_state;
	logic                                 emit;
	logic                                 char_ok;
	logic [i2d_pkg::DigitWidth-1:0]       top_digit;

	assign num.ready  = (state_q == ST_IDLE);
	assign accept     = num.valid && num.ready;
	assign slot_free  = !text_valid_q || text.ready;
	assign text_state = (state_q == ST_SIGN) || (state_q == ST_DIGIT);
	assign emit       = text_state && slot_free;
	assign top_digit  = dig_q[i2d_pkg::BcdWidth-1 -: i2d_pkg::DigitWidth];

	assign cvt_req.start = accept;
	assign cvt_req.mag   = num.value[i2d_pkg::ValueWidth-1] ?
		(~num.value + 1'b1) : num.value;

	i2d_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cvt_req),
		.rsp    (cvt_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			neg_q        <= 1'b0;
			dig_q        <= '0;
			left_q       <= '0;
			text_valid_q <= 1'b0;
			text_char_q  <= '0;
			last_q       <= 1'b0;
		end else begin
			if (emit) begin
				text_valid_q <= 1'b1;
			end else if (text_valid_q && text.ready) begin
				text_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= num.value[i2d_pkg::ValueWidth-1];
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (cvt_rsp.done) begin
						dig_q   <= cvt_rsp.bcd;
						left_q  <= i2d_pkg::DigitCntWidth'(i2d_pkg::NumDigits);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// drop leading zeros, keeping at least one digit
					if (top_digit == '0 && left_q > 1) begin
						dig_q  <= {dig_q[i2d_pkg::BcdWidth-i2d_pkg::DigitWidth-1:0],
							{i2d_pkg::DigitWidth{1'b0}}};
						left_q <= left_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						text_char_q  <= i2d_pkg::CharMinus;
						last_q       <= 1'b0;
						state_q      <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (slot_free) begin
						text_char_q  <= i2d_pkg::CharZero +
							{{(i2d_pkg::CharWidth-i2d_pkg::DigitWidth){1'b0}}, top_digit};
						last_q       <= (left_q == 1);
						dig_q        <= {dig_q[i2d_pkg::BcdWidth-i2d_pkg::DigitWidth-1:0],
							{i2d_pkg::DigitWidth{1'b0}}};
						left_q       <= left_q - 1'b1;
						if (left_q == 1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign text.valid     = text_valid_q;
	assign text.text_char = text_char_q;
	assign text.last_char = last_q;

	assign char_ok = (text_char_q == i2d_pkg::CharMinus) ||
		((text_char_q >= i2d_pkg::CharZero) && (text_char_q <= i2d_pkg::CharZero + 8'd9));

	`I2D_ASSERT(a_busy_after_accept, accept |=> !num.ready, "input taken while converting")
	`I2D_ASSERT(a_done_in_conv, cvt_rsp.done |-> (state_q == ST_CONV), "stray conversion done")
	`I2D_ASSERT(a_digits_left, text_state |-> (left_q != 0), "digit count ran out")
	`I2D_ASSERT_ALWAYS(a_char_set, text_valid_q |-> char_ok, "bad character")

endmodule
`default_nettype wire
